### src/isoe_pkg.sv
// Shared types and constants for the integer stack operation executor.
// No dependencies; isoe_cell and integer_stack_op_executor_core use it.
package isoe_pkg;

    // Operation codes on the func field
    localparam logic [2:0] FUNC_PUSH  = 3'd0;
    localparam logic [2:0] FUNC_PRINT = 3'd1;
    localparam logic [2:0] FUNC_POP   = 3'd2;
    localparam logic [2:0] FUNC_PEEK  = 3'd3;
    localparam logic [2:0] FUNC_SWAP  = 3'd4;

    // Status codes on the status field
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_ARG    = 3'd1;
    localparam logic [2:0] ST_POP_EMPTY  = 3'd2;
    localparam logic [2:0] ST_PEEK_EMPTY = 3'd3;
    localparam logic [2:0] ST_SWAP_SHORT = 3'd4;
    localparam logic [2:0] ST_OVERFLOW   = 3'd5;
    localparam logic [2:0] ST_HALTED     = 3'd6;

    localparam int unsigned DATA_W = 32;

    // Per-cycle move applied to every cell of the chain
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP,
        OP_SWAP,
        OP_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctl_t;

endpackage

### src/integer_stack_op_executor_core.sv
// Stack-machine executor on a bounded LIFO of signed 32-bit entries.
// Push, pop, peek and swap take one request per cycle while the result stage
// is free and answer in the next cycle through that registered stage; the
// stack is a chain of DEPTH cells with the top in cell 0, so each of these
// moves every cell by at most one place. Print of n entries rotates the
// first n cells of the chain by one place a cycle while the output is free,
// and each rotation sends the top out, which leaves the stack as it was;
// input is held off meanwhile. An invalid push argument, pop or peek on an
// empty stack and swap on fewer than two entries halt the block for good,
// and every later request answers halted. Depends on isoe_pkg and isoe_cell.
module integer_stack_op_executor_core #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         func,
    input  logic signed [isoe_pkg::DATA_W-1:0] push_value,
    input  logic                               arg_ok,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [isoe_pkg::DATA_W-1:0] result_value,
    output logic                               has_value,
    output logic [2:0]                         status,
    output logic                               last
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);
    localparam logic [CW-1:0] ONE  = CW'(1);
    localparam logic [CW-1:0] TWO  = CW'(2);

    logic [CW-1:0] fc_reg, fc_next;
    logic          halted_reg, halted_next;
    logic          printing_reg, printing_next;
    logic [CW-1:0] rem_reg, rem_next;

    logic                               out_valid_reg, out_valid_next;
    logic signed [isoe_pkg::DATA_W-1:0] value_reg, value_next;
    logic                               has_reg, has_next;
    logic [2:0]                         status_reg, status_next;
    logic                               last_reg, last_next;

    logic                               accept;
    logic                               out_free;
    logic                               print_step;
    isoe_pkg::cell_ctl_t                ctl;
    logic [DEPTH-1:0]                   end_sel;
    logic signed [isoe_pkg::DATA_W-1:0] cell_val [DEPTH];

    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = !printing_reg && out_free;
    assign accept     = in_valid && in_ready;
    assign print_step = printing_reg && out_free;

    // Build the chain of cells; cell 0 is the top of the stack
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [isoe_pkg::DATA_W-1:0] up_v;
        logic signed [isoe_pkg::DATA_W-1:0] down_v;

        assign end_sel[g] = (fc_reg == CW'(g + 1));

        if (g == 0)
        begin : g_top
            assign up_v = push_value;
        end
        else
        begin : g_mid
            assign up_v = cell_val[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_bot
            assign down_v = '0;
        end
        else
        begin : g_low
            assign down_v = cell_val[g+1];
        end

        isoe_cell #(
            .INDEX(g)
        ) u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .is_end  (end_sel[g]),
            .up_val  (up_v),
            .down_val(down_v),
            .wrap_val(cell_val[0]),
            .val     (cell_val[g])
        );
    end

    // Decode the request and the print walk into state and result updates
    always_comb
    begin
        ctl.op         = isoe_pkg::OP_HOLD;
        fc_next        = fc_reg;
        halted_next    = halted_reg;
        printing_next  = printing_reg;
        rem_next       = rem_reg;
        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        value_next     = value_reg;
        has_next       = has_reg;
        status_next    = status_reg;
        last_next      = last_reg;

        if (print_step)
        begin
            // Send the top out and rotate the live cells by one place
            ctl.op         = isoe_pkg::OP_ROTATE;
            out_valid_next = 1'b1;
            value_next     = cell_val[0];
            has_next       = 1'b1;
            status_next    = isoe_pkg::ST_OK;
            last_next      = (rem_reg == ONE);
            rem_next       = rem_reg - ONE;
            printing_next  = (rem_reg != ONE);
        end
        else if (accept)
        begin
            out_valid_next = 1'b1;
            value_next     = '0;
            has_next       = 1'b0;
            status_next    = isoe_pkg::ST_OK;
            last_next      = 1'b1;
            if (halted_reg)
            begin
                status_next = isoe_pkg::ST_HALTED;
            end
            else
            begin
                unique case (func)
                    isoe_pkg::FUNC_PUSH:
                    begin
                        if (!arg_ok)
                        begin
                            status_next = isoe_pkg::ST_BAD_ARG;
                            halted_next = 1'b1;
                        end
                        else if (fc_reg == FULL)
                        begin
                            status_next = isoe_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            ctl.op  = isoe_pkg::OP_PUSH;
                            fc_next = fc_reg + ONE;
                        end
                    end
                    isoe_pkg::FUNC_PRINT:
                    begin
                        // Start the walk; the empty case answers at once
                        if (fc_reg != '0)
                        begin
                            out_valid_next = 1'b0;
                            printing_next  = 1'b1;
                            rem_next       = fc_reg;
                        end
                    end
                    isoe_pkg::FUNC_POP:
                    begin
                        if (fc_reg == '0)
                        begin
                            status_next = isoe_pkg::ST_POP_EMPTY;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            ctl.op  = isoe_pkg::OP_POP;
                            fc_next = fc_reg - ONE;
                        end
                    end
                    isoe_pkg::FUNC_PEEK:
                    begin
                        if (fc_reg == '0)
                        begin
                            status_next = isoe_pkg::ST_PEEK_EMPTY;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            value_next = cell_val[0];
                            has_next   = 1'b1;
                        end
                    end
                    isoe_pkg::FUNC_SWAP:
                    begin
                        if (fc_reg < TWO)
                        begin
                            status_next = isoe_pkg::ST_SWAP_SHORT;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            ctl.op = isoe_pkg::OP_SWAP;
                        end
                    end
                    default:
                    begin
                        status_next = isoe_pkg::ST_OK;
                    end
                endcase
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg        <= '0;
            halted_reg    <= 1'b0;
            printing_reg  <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fc_reg        <= fc_next;
            halted_reg    <= halted_next;
            printing_reg  <= printing_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        has_reg    <= has_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = value_reg;
    assign has_value    = has_reg;
    assign status       = status_reg;
    assign last         = last_reg;

    // Halt is sticky
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared");

    // Fill count never passes the depth
    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= FULL)
        else $error("fill count beyond depth");

    // The walk counter stays within the live entries
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        printing_reg |-> (rem_reg != '0) && (rem_reg <= fc_reg))
        else $error("print walk counter out of range");

    // The end of a walk leaves its final result marked last
    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(printing_reg) |-> out_valid_reg && last_reg && has_reg)
        else $error("print walk ended without last result");

endmodule

### src/isoe_cell.sv
// One stack cell of the chain: holds one entry and moves it to a neighbor.
// Depends on isoe_pkg.
module isoe_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                              clk,
    input  isoe_pkg::cell_ctl_t               ctl,
    input  logic                              is_end,
    input  logic signed [isoe_pkg::DATA_W-1:0] up_val,
    input  logic signed [isoe_pkg::DATA_W-1:0] down_val,
    input  logic signed [isoe_pkg::DATA_W-1:0] wrap_val,
    output logic signed [isoe_pkg::DATA_W-1:0] val
);

    logic signed [isoe_pkg::DATA_W-1:0] val_reg;
    logic signed [isoe_pkg::DATA_W-1:0] val_next;

    // Pick the new entry from the neighbor that the move names
    always_comb
    begin
        val_next = val_reg;
        unique case (ctl.op)
            isoe_pkg::OP_HOLD:   val_next = val_reg;
            isoe_pkg::OP_PUSH:   val_next = up_val;
            isoe_pkg::OP_POP:    val_next = down_val;
            isoe_pkg::OP_SWAP:
            begin
                if (INDEX == 0)
                begin
                    val_next = down_val;
                end
                else if (INDEX == 1)
                begin
                    val_next = up_val;
                end
            end
            isoe_pkg::OP_ROTATE: val_next = is_end ? wrap_val : down_val;
            default:             val_next = val_reg;
        endcase
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule
